### sv/quadrature_pd_position_loop_macros.svh
`ifndef QUADRATURE_PD_POSITION_LOOP_MACROS_SVH
`define QUADRATURE_PD_POSITION_LOOP_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define QPDPL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QPDPL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/qpdpl_pkg.sv
`default_nettype none

package qpdpl_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int ERR_W             = 48;
    localparam int CFG_W             = 16;
    localparam int MPL_W             = CFG_W + 1;
    localparam int STEP_W            = 5;
    localparam int FRAC_SHIFT        = 8;
    localparam int LIMIT_SHIFT       = 16;
    localparam int OUT_W             = 64;
    localparam int POS_OUT_W         = 32;
    localparam int MAG_W             = 16;
    localparam int IN_TDATA_W        = 8;
    localparam int OUT_TDATA_W       = 56;
    localparam int APB_ADDR_W        = 5;
    localparam int APB_DATA_W        = 32;
    localparam int REG_IDX_W         = 3;

    localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCALE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KD     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HI     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LO     = 3'd5;

    localparam logic [CFG_W-1:0] PERIOD_RST = 16'd100;
    localparam logic [CFG_W-1:0] SCALE_RST  = 16'd8716;
    localparam logic [CFG_W-1:0] KP_RST     = 16'd256;
    localparam logic [CFG_W-1:0] KD_RST     = 16'd0;
    localparam logic [CFG_W-1:0] HI_RST     = 16'd180;
    localparam logic [CFG_W-1:0] LO_RST     = 16'hFF4C;

    // multiplier operand select
    localparam logic [1:0] SEL_ANGLE = 2'd0;
    localparam logic [1:0] SEL_KP    = 2'd1;
    localparam logic [1:0] SEL_KD    = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] period_ticks;
        logic [CFG_W-1:0] angle_scale;
        logic [CFG_W-1:0] gain_p;
        logic [CFG_W-1:0] gain_d;
        logic [CFG_W-1:0] limit_high;
        logic [CFG_W-1:0] limit_low;
    } cfg_t;

    typedef struct packed {
        logic       accept;
        logic       mul_load;
        logic       mul_step;
        logic [1:0] sel;
        logic       err_load;
        logic       pp_load;
        logic       fin_sum;
        logic       fin_clamp;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic upd_now;
        logic mul_done;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

### sv/qpdpl_ctrl.sv
`default_nettype none

module qpdpl_ctrl
    import qpdpl_pkg::*;
(
    input  wire     aclk,
    input  wire     aresetn,
    input  wire     s_tvalid,
    output logic    s_tready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_CLAMP = 3'd4;
    localparam logic [2:0] ST_LOAD  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.sel    = sel_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.upd_now) begin
                        sel_next   = SEL_ANGLE;
                        state_next = ST_START;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_START: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                if (!sts.mul_done) begin
                    cmd.mul_step = 1'b1;
                end else begin
                    case (sel_reg)
                        SEL_ANGLE: begin
                            cmd.err_load = 1'b1;
                            sel_next     = SEL_KP;
                            state_next   = ST_START;
                        end
                        SEL_KP: begin
                            cmd.pp_load = 1'b1;
                            sel_next    = SEL_KD;
                            state_next  = ST_START;
                        end
                        default: begin
                            state_next = ST_SUM;
                        end
                    endcase
                end
            end
            ST_SUM: begin
                cmd.fin_sum = 1'b1;
                state_next  = ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.fin_clamp = 1'b1;
                state_next    = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= SEL_ANGLE;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

`default_nettype wire

### sv/qpdpl_dp.sv
`default_nettype none

module qpdpl_dp
    import qpdpl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  dp_cmd_t                 cmd,
    output dp_sts_t                 sts,
    input  cfg_t                    cfg,
    input  wire                     phase_a,
    input  wire                     phase_b,
    input  wire                     m_tready,
    output logic                    m_tvalid,
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    output logic                    m_tuser
);

    localparam int MC_W  = ((POSITION_BITS > ERR_W) ? POSITION_BITS : ERR_W) + 1;
    localparam int ACC_W = MC_W + MPL_W;
    localparam int SUM_W = ACC_W + 1;

    localparam logic signed [ACC_W-1:0] EMAX = (ACC_W'(1) <<< (ERR_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] EMIN = -EMAX - ACC_W'(1);
    localparam logic signed [SUM_W-1:0] OMAX = (SUM_W'(1) <<< (OUT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] OMIN = -OMAX - SUM_W'(1);

    // loop state
    logic                            last_a_reg, last_b_reg;
    logic signed [POSITION_BITS-1:0] count_reg, count_next;
    logic                            err_seen_reg;
    logic [CFG_W-1:0]                tick_reg;
    logic signed [ERR_W-1:0]         prev_reg;
    logic                            dir_reg;
    logic [MAG_W-1:0]                mag_reg;
    logic                            upd_reg;
    logic [STEP_W-1:0]               step_reg;
    logic                            m_tvalid_reg;

    // work registers
    logic signed [ERR_W-1:0]         err_reg, err_next;
    logic signed [ACC_W-1:0]         mcand_reg;
    logic [MPL_W-1:0]                mpl_reg;
    logic signed [ACC_W-1:0]         acc_reg;
    logic signed [ACC_W-1:0]         pp_reg;
    logic signed [OUT_W-1:0]         sum_reg, sum_next;
    logic [OUT_TDATA_W-1:0]          m_tdata_reg;
    logic                            m_tuser_reg;

    logic                            up, down, dbl_change, upd_now;
    logic signed [ERR_W:0]           diff;
    logic signed [ACC_W-1:0]         mc_sel, term, shifted;
    logic [MPL_W-1:0]                mpl_sel;
    logic signed [SUM_W-1:0]         sum_full;
    logic signed [OUT_W-1:0]         hi_lim, lo_lim, clamped, abs_o;
    logic signed [OUT_W-1:0]         pos_ext;

    assign up         = phase_a ^ last_b_reg;
    assign down       = last_a_reg ^ phase_b;
    assign dbl_change = (last_a_reg ^ phase_a) & (last_b_reg ^ phase_b);
    assign upd_now    = (tick_reg == '0) || (tick_reg >= cfg.period_ticks);

    always_comb begin
        count_next = count_reg;
        if (up && !down) begin
            count_next = count_reg + POSITION_BITS'(1);
        end else if (down && !up) begin
            count_next = count_reg - POSITION_BITS'(1);
        end
    end

    assign diff = $signed({err_reg[ERR_W-1], err_reg}) - $signed({prev_reg[ERR_W-1], prev_reg});

    always_comb begin
        case (cmd.sel)
            SEL_ANGLE: begin
                mc_sel  = ACC_W'(count_reg);
                mpl_sel = {1'b0, cfg.angle_scale};
            end
            SEL_KP: begin
                mc_sel  = ACC_W'(err_reg);
                mpl_sel = {cfg.gain_p[CFG_W-1], cfg.gain_p};
            end
            default: begin
                mc_sel  = ACC_W'(diff);
                mpl_sel = {cfg.gain_d[CFG_W-1], cfg.gain_d};
            end
        endcase
    end

    // top multiplier bit carries negative weight
    always_comb begin
        term = '0;
        if (mpl_reg[0]) begin
            term = (step_reg == STEP_W'(MPL_W - 1)) ? -mcand_reg : mcand_reg;
        end
    end

    assign shifted = acc_reg >>> FRAC_SHIFT;

    always_comb begin
        if (shifted > EMAX) begin
            err_next = ERR_W'(EMAX);
        end else if (shifted < EMIN) begin
            err_next = ERR_W'(EMIN);
        end else begin
            err_next = shifted[ERR_W-1:0];
        end
    end

    assign sum_full = SUM_W'(pp_reg) + SUM_W'(acc_reg);

    always_comb begin
        if (sum_full > OMAX) begin
            sum_next = OUT_W'(OMAX);
        end else if (sum_full < OMIN) begin
            sum_next = OUT_W'(OMIN);
        end else begin
            sum_next = sum_full[OUT_W-1:0];
        end
    end

    assign hi_lim = OUT_W'($signed(cfg.limit_high)) <<< LIMIT_SHIFT;
    assign lo_lim = OUT_W'($signed(cfg.limit_low)) <<< LIMIT_SHIFT;

    always_comb begin
        if (sum_reg > hi_lim) begin
            clamped = hi_lim;
        end else if (sum_reg < lo_lim) begin
            clamped = lo_lim;
        end else begin
            clamped = sum_reg;
        end
    end

    assign abs_o   = (clamped < 0) ? -clamped : clamped;
    assign pos_ext = OUT_W'(count_reg);

    assign sts.upd_now  = upd_now;
    assign sts.mul_done = (step_reg == STEP_W'(MPL_W));
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_a_reg   <= 1'b0;
            last_b_reg   <= 1'b0;
            count_reg    <= '0;
            err_seen_reg <= 1'b0;
            tick_reg     <= '0;
            prev_reg     <= '0;
            dir_reg      <= 1'b0;
            mag_reg      <= '0;
            upd_reg      <= 1'b0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                last_a_reg <= phase_a;
                last_b_reg <= phase_b;
                count_reg  <= count_next;
                upd_reg    <= upd_now;
                if (dbl_change) begin
                    err_seen_reg <= 1'b1;
                end
                tick_reg <= upd_now ? CFG_W'(1) : tick_reg + CFG_W'(1);
            end
            if (cmd.mul_load) begin
                step_reg <= '0;
            end else if (cmd.mul_step) begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.fin_clamp) begin
                prev_reg <= err_reg;
                dir_reg  <= (clamped > 0);
                mag_reg  <= abs_o[LIMIT_SHIFT +: MAG_W];
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            mcand_reg <= mc_sel;
            mpl_reg   <= mpl_sel;
            acc_reg   <= '0;
        end else if (cmd.mul_step) begin
            mcand_reg <= mcand_reg <<< 1;
            mpl_reg   <= mpl_reg >> 1;
            acc_reg   <= acc_reg + term;
        end
        if (cmd.err_load) begin
            err_reg <= err_next;
        end
        if (cmd.pp_load) begin
            pp_reg <= acc_reg;
        end
        if (cmd.fin_sum) begin
            sum_reg <= sum_next;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= OUT_TDATA_W'({mag_reg, dir_reg, err_seen_reg,
                                         pos_ext[POS_OUT_W-1:0]});
            m_tuser_reg <= upd_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

### sv/quadrature_pd_position_loop.sv
// Quadrature encoder counter with a proportional-derivative position loop.
// Input stream s_*: one request per encoder tick, s_tdata[0] = phase A,
// s_tdata[1] = phase B. Output stream m_*: exactly one result per request:
// position, sticky phase error, drive direction and drive magnitude in
// m_tdata, and m_tuser set when the control output was recomputed.
// Registers (period, angle scale, gains, limits) sit on the APB port at
// byte addresses 0, 4, ... 20; pready is always high.
// A tick without a control update goes from accept to the load state and
// then to the output register. An update tick runs three 17-step shift-add
// multiplies (angle, proportional, derivative) on one shared multiplier,
// plus sum, clamp and load stages. One request is in work at a time; the
// next is accepted as soon as the result sits in the output register.
// When the receiver stalls, the result is held in the output register and
// a finished next result waits for it to drain.
// Reset (aresetn low, synchronous) restores register defaults, clears the
// count, error flag, tick counter, held drive and the output valid.
`default_nettype none

module quadrature_pd_position_loop
    import qpdpl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    // [0] phase_a, [1] phase_b
    input  wire [IN_TDATA_W-1:0]    s_tdata,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    // [31:0] position, [32] phase_error, [33] drive_direction,
    // [49:34] drive_magnitude
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    // [0] updated
    output logic                    m_tuser,
    output logic                    m_tvalid,
    input  wire                     m_tready,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire [APB_ADDR_W-1:0]    paddr,
    input  wire [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    cfg_t                   cfg_reg;
    dp_cmd_t                cmd;
    dp_sts_t                sts;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period_ticks <= PERIOD_RST;
            cfg_reg.angle_scale  <= SCALE_RST;
            cfg_reg.gain_p       <= KP_RST;
            cfg_reg.gain_d       <= KD_RST;
            cfg_reg.limit_high   <= HI_RST;
            cfg_reg.limit_low    <= LO_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PERIOD: cfg_reg.period_ticks <= pwdata[CFG_W-1:0];
                REG_SCALE:  cfg_reg.angle_scale  <= pwdata[CFG_W-1:0];
                REG_KP:     cfg_reg.gain_p       <= pwdata[CFG_W-1:0];
                REG_KD:     cfg_reg.gain_d       <= pwdata[CFG_W-1:0];
                REG_HI:     cfg_reg.limit_high   <= pwdata[CFG_W-1:0];
                REG_LO:     cfg_reg.limit_low    <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PERIOD: prdata = APB_DATA_W'(cfg_reg.period_ticks);
            REG_SCALE:  prdata = APB_DATA_W'(cfg_reg.angle_scale);
            REG_KP:     prdata = APB_DATA_W'(cfg_reg.gain_p);
            REG_KD:     prdata = APB_DATA_W'(cfg_reg.gain_d);
            REG_HI:     prdata = APB_DATA_W'(cfg_reg.limit_high);
            REG_LO:     prdata = APB_DATA_W'(cfg_reg.limit_low);
            default:    prdata = '0;
        endcase
    end

    qpdpl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    qpdpl_dp #(
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .cfg      (cfg_reg),
        .phase_a  (s_tdata[0]),
        .phase_b  (s_tdata[1]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### sv/qpdpl_checker.sv
`default_nettype none
`include "quadrature_pd_position_loop_macros.svh"

module qpdpl_checker
    import qpdpl_pkg::*;
(
    input wire                    aclk,
    input wire                    aresetn,
    input wire                    s_tvalid,
    input wire                    s_tready,
    input wire                    m_tvalid,
    input wire                    m_tready,
    input wire [OUT_TDATA_W-1:0]  m_tdata,
    input wire                    m_tuser
);

    `QPDPL_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `QPDPL_ASSERT_NXT(a_one_request, s_tvalid && s_tready, !s_tready, "second request taken while one is in work")
    `QPDPL_ASSERT_NXT(a_err_sticky, m_tvalid && m_tdata[32], !m_tvalid || m_tdata[32], "phase error flag dropped")
    `QPDPL_ASSERT_IMP(a_mag_bound, m_tvalid && m_tdata[49], m_tdata[48:34] == 15'd0, "drive magnitude above full scale")

endmodule

bind quadrature_pd_position_loop qpdpl_checker u_qpdpl_checker (.*);

`default_nettype wire
